[design/cwsc_pkg.sv]
// ----------------------------------------------------------------------------
// cwsc_pkg
// Shared types, codes and defaults for the congestion window sender core.
// ----------------------------------------------------------------------------
package cwsc_pkg;

    localparam int SEQ_W = 13;
    localparam int WIN_W = 7;
    localparam int CNT_W = 7;
    localparam int CFG_W = 13;

    localparam int MAX_PACKETS_DEF = 4096;
    localparam int MAX_WINDOW_DEF  = 64;
    localparam int THR_RESET       = 16;
    localparam int CNT_SAT         = 127;

    // command codes
    localparam logic [1:0] CMD_ROUND = 2'd0;
    localparam logic [1:0] CMD_ACK   = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;
    localparam logic [1:0] CMD_START = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_SEND   = 2'd0;
    localparam logic [1:0] KIND_ACK    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;
    localparam logic [1:0] KIND_IDLE   = 2'd3;

    // register indexes
    localparam logic REG_TOTAL = 1'b0;
    localparam logic REG_THR   = 1'b1;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [SEQ_W-1:0] ack_seq;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       kind;
        logic [SEQ_W-1:0] seq;
        logic             resend;
        logic             ack_accepted;
        logic             timed_out;
        logic [WIN_W-1:0] window;
        logic [WIN_W-1:0] threshold;
        logic [SEQ_W-1:0] base_seq;
        logic             done_res;
        logic             last;
    } t_res_item;

endpackage

[design/cwsc_ram.sv]
// ----------------------------------------------------------------------------
// cwsc_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module cwsc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/congestion_window_sender_core.sv]
// ----------------------------------------------------------------------------
// congestion_window_sender_core
// Sender window engine: slow start, congestion avoidance, selective acks.
// ----------------------------------------------------------------------------
// Usage
//   Commands enter on i_in with i_start while o_busy is low. Results leave on
//   o_res, one per cycle, each marked by o_res_valid for one cycle; the
//   receiver takes every result as it comes. o_res.last marks the final
//   result of a command.
//   Per-packet acked and sent bits live in one 2-bit wide RAM with one read
//   port, so the cost of a command is set by RAM sweeps:
//     start transfer : a sweep clearing every RAM entry, then one result
//     round start    : one result per packet sent, one a cycle while busy
//                      sending; one idle result if the transfer is done
//     ack            : one result, via S_ACK if inside the window
//     round close    : one result, after a scan that skips acked packets while
//                      searching for the new base
//   Configuration writes on i_cfg_we take effect at once; write only while
//   idle. After reset the core clears every RAM entry with o_busy high
//   and emits nothing.
// ----------------------------------------------------------------------------
module congestion_window_sender_core
    import cwsc_pkg::*;
#(
    parameter int MAX_PACKETS = MAX_PACKETS_DEF,
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_in_item         i_in,
    output logic             o_busy,
    output logic             o_res_valid,
    output t_res_item        o_res,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_PACKETS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SEND,
        S_ACK,
        S_SCAN
    } t_state;

    t_state           r_state;
    logic [SEQ_W-1:0] r_total;
    logic [WIN_W-1:0] r_init_thr;
    logic [SEQ_W-1:0] r_base;
    logic [WIN_W-1:0] r_window;
    logic [WIN_W-1:0] r_thr;
    logic [CNT_W-1:0] r_sent_cnt;
    logic [CNT_W-1:0] r_ack_cnt;
    logic             r_done;
    logic [SEQ_W-1:0] r_ptr;
    logic [SEQ_W-1:0] r_end;
    logic             r_to;
    logic [AW-1:0]    r_clr;
    logic             r_clr_emit;
    logic             r_res_valid;
    t_res_item        r_res;

    logic [AW-1:0]    ram_raddr;
    logic [AW-1:0]    ram_waddr;
    logic [1:0]       ram_wdata;
    logic [1:0]       ram_rdata;
    logic             ram_we;

    logic [SEQ_W-1:0] eff_total;
    logic [SEQ_W:0]   win_end;
    logic [SEQ_W-1:0] round_end;
    logic             ack_ok;
    logic             accept;
    logic [WIN_W-1:0] thr_clamped;
    logic [WIN_W:0]   win_grow;
    logic [WIN_W-1:0] win_next;
    logic [WIN_W-1:0] thr_next;
    logic             close_to;
    logic [CNT_W-1:0] ack_cnt_inc;

    function automatic t_res_item make_res(
        input logic [1:0]       kind,
        input logic [SEQ_W-1:0] seq,
        input logic             resend,
        input logic             acc,
        input logic             to,
        input logic [WIN_W-1:0] win,
        input logic [WIN_W-1:0] thr,
        input logic [SEQ_W-1:0] base,
        input logic             done,
        input logic             last
    );
        t_res_item r;
        r.kind         = kind;
        r.seq          = seq;
        r.resend       = resend;
        r.ack_accepted = acc;
        r.timed_out    = to;
        r.window       = win;
        r.threshold    = thr;
        r.base_seq     = base;
        r.done_res     = done;
        r.last         = last;
        return r;
    endfunction

    cwsc_ram #(
        .WIDTH (2),
        .DEPTH (MAX_PACKETS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // window arithmetic and ack check
    always_comb begin
        eff_total = (32'(r_total) > MAX_PACKETS) ? SEQ_W'(MAX_PACKETS) : r_total;
        win_end   = {1'b0, r_base} + (SEQ_W+1)'(r_window);
        round_end = ((win_end - (SEQ_W+1)'(1)) > {1'b0, eff_total}) ?
                    eff_total : SEQ_W'(win_end - (SEQ_W+1)'(1));
        ack_ok    = !r_done && (i_in.ack_seq != '0) && (i_in.ack_seq >= r_base) &&
                    ({1'b0, i_in.ack_seq} < win_end) && (i_in.ack_seq <= eff_total);
        accept    = i_start && (r_state == S_IDLE);

        if (r_init_thr == '0) begin
            thr_clamped = WIN_W'(1);
        end else if (32'(r_init_thr) > MAX_WINDOW) begin
            thr_clamped = WIN_W'(MAX_WINDOW);
        end else begin
            thr_clamped = r_init_thr;
        end

        win_grow = (r_window < r_thr) ? {r_window, 1'b0} : ({1'b0, r_window} + 1'b1);
        close_to = r_ack_cnt < r_sent_cnt;
        if (close_to) begin
            win_next = WIN_W'(1);
            thr_next = ((r_window >> 1) == '0) ? WIN_W'(1) : (r_window >> 1);
        end else begin
            win_next = (32'(win_grow) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW)
                                                     : WIN_W'(win_grow);
            thr_next = r_thr;
        end
        ack_cnt_inc = (r_ack_cnt == CNT_W'(CNT_SAT)) ? r_ack_cnt : (r_ack_cnt + 1'b1);
    end

    // map ram addressing
    always_comb begin
        ram_raddr = AW'(r_ptr);
        ram_we    = 1'b0;
        ram_waddr = AW'(r_ptr - SEQ_W'(1));
        ram_wdata = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.cmd == CMD_ACK) begin
                    ram_raddr = AW'(i_in.ack_seq - SEQ_W'(1));
                end else begin
                    ram_raddr = AW'(r_base - SEQ_W'(1));
                end
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
            end
            S_SEND: begin
                ram_we    = 1'b1;
                ram_wdata = {ram_rdata[1], 1'b1};
            end
            S_ACK: begin
                ram_we    = 1'b1;
                ram_wdata = {1'b1, ram_rdata[0]};
            end
            S_SCAN: begin
                ram_we = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control sequencer and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_total     <= SEQ_W'(1);
            r_init_thr  <= WIN_W'(THR_RESET);
            r_base      <= SEQ_W'(1);
            r_window    <= WIN_W'(1);
            r_thr       <= WIN_W'(THR_RESET);
            r_sent_cnt  <= '0;
            r_ack_cnt   <= '0;
            r_done      <= 1'b0;
            r_clr       <= '0;
            r_clr_emit  <= 1'b0;
            r_res_valid <= 1'b0;
            r_ptr       <= '0;
            r_end       <= '0;
            r_to        <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;

            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TOTAL: r_total    <= i_cfg_data;
                    REG_THR:   r_init_thr <= i_cfg_data[WIN_W-1:0];
                    default:   r_total    <= r_total;
                endcase
            end

            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr == AW'(MAX_PACKETS - 1)) begin
                        r_state     <= S_IDLE;
                        r_res_valid <= r_clr_emit;
                        r_res       <= make_res(KIND_IDLE, '0, 1'b0, 1'b0, 1'b0,
                                                r_window, r_thr, r_base, r_done, 1'b1);
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_in.cmd)
                            CMD_START: begin
                                r_state    <= S_CLEAR;
                                r_clr      <= '0;
                                r_clr_emit <= 1'b1;
                                r_base     <= SEQ_W'(1);
                                r_window   <= WIN_W'(1);
                                r_thr      <= thr_clamped;
                                r_sent_cnt <= '0;
                                r_ack_cnt  <= '0;
                                r_done     <= 1'b0;
                            end
                            CMD_ROUND: begin
                                r_sent_cnt <= '0;
                                r_ack_cnt  <= '0;
                                if (r_done || (r_base > eff_total)) begin
                                    r_res_valid <= 1'b1;
                                    r_res <= make_res(KIND_IDLE, '0, 1'b0, 1'b0, 1'b0,
                                                      r_window, r_thr, r_base, r_done, 1'b1);
                                end else begin
                                    r_state <= S_SEND;
                                    r_ptr   <= r_base;
                                    r_end   <= round_end;
                                end
                            end
                            CMD_ACK: begin
                                if (ack_ok) begin
                                    r_state   <= S_ACK;
                                    r_ptr     <= i_in.ack_seq;
                                    r_ack_cnt <= ack_cnt_inc;
                                end else begin
                                    r_res_valid <= 1'b1;
                                    r_res <= make_res(KIND_ACK, i_in.ack_seq, 1'b0, 1'b0,
                                                      1'b0, r_window, r_thr, r_base,
                                                      r_done, 1'b1);
                                end
                            end
                            CMD_CLOSE: begin
                                if (r_done) begin
                                    r_res_valid <= 1'b1;
                                    r_res <= make_res(KIND_STATUS, '0, 1'b0, 1'b0, 1'b0,
                                                      r_window, r_thr, r_base, r_done, 1'b1);
                                end else begin
                                    r_window   <= win_next;
                                    r_thr      <= thr_next;
                                    r_sent_cnt <= '0;
                                    r_ack_cnt  <= '0;
                                    r_to       <= close_to;
                                    r_ptr      <= r_base;
                                    if (r_base > eff_total) begin
                                        r_done      <= 1'b1;
                                        r_res_valid <= 1'b1;
                                        r_res <= make_res(KIND_STATUS, '0, 1'b0, 1'b0,
                                                          close_to, win_next, thr_next,
                                                          r_base, 1'b1, 1'b1);
                                    end else begin
                                        r_state <= S_SCAN;
                                    end
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SEND: begin
                    r_res_valid <= 1'b1;
                    r_sent_cnt  <= r_sent_cnt + 1'b1;
                    r_res <= make_res(KIND_SEND, r_ptr, ram_rdata[0], 1'b0, 1'b0,
                                      r_window, r_thr, r_base, r_done, r_ptr == r_end);
                    if (r_ptr == r_end) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_ACK: begin
                    r_state     <= S_IDLE;
                    r_res_valid <= 1'b1;
                    r_res <= make_res(KIND_ACK, r_ptr, 1'b0, 1'b1, 1'b0,
                                      r_window, r_thr, r_base, r_done, 1'b1);
                end
                S_SCAN: begin
                    // first unacked packet from the old base becomes the new base
                    if (!ram_rdata[1]) begin
                        r_state     <= S_IDLE;
                        r_base      <= r_ptr;
                        r_res_valid <= 1'b1;
                        r_res <= make_res(KIND_STATUS, '0, 1'b0, 1'b0, r_to,
                                          r_window, r_thr, r_ptr, r_done, 1'b1);
                    end else if (r_ptr >= eff_total) begin
                        r_state     <= S_IDLE;
                        r_done      <= 1'b1;
                        r_res_valid <= 1'b1;
                        r_res <= make_res(KIND_STATUS, '0, 1'b0, 1'b0, r_to,
                                          r_window, r_thr, r_base, 1'b1, 1'b1);
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

[design/cwsc_checker.sv]
// ----------------------------------------------------------------------------
// cwsc_checker
// Port level checks for the congestion window sender core.
// ----------------------------------------------------------------------------
module cwsc_checker
    import cwsc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_start,
    input t_in_item         i_in,
    input logic             o_busy,
    input logic             o_res_valid,
    input t_res_item        o_res
);

    // reset starts the map clearing sweep
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> o_busy)
        else $error("core not busy after reset");

    // a start transfer always runs a clearing sweep
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_in.cmd == CMD_START)) |=> o_busy)
        else $error("start transfer did not clear the maps");

    // only a round start gives more than one result
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.kind != KIND_SEND)) |-> o_res.last)
        else $error("non-send result not marked last");

    // a result needs a command strobe or work in progress in the cycle before
    a_res_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(o_busy || i_start))
        else $error("result with no command behind it");

endmodule

bind congestion_window_sender_core cwsc_checker u_cwsc_checker (.*);
